// ===== design/assert_macros.svh =====
// Assertion macros used by the datapath design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/dic_pkg.sv =====
// Types, constants and operation codes of the dynamic inversion counter.
package dic_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int IVAL_W  = 32;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 19;
  localparam int ELEMS_W = 11;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_SWAP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IVAL_W-1:0] item_value;
    logic [POS_W-1:0]  first_position;
    logic [POS_W-1:0]  second_position;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] inversion_count;
    logic [ELEMS_W-1:0] element_count;
    logic               error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_SCAN,
    ST_WR_LO,
    ST_WR_HI,
    ST_WR_APP,
    ST_FINISH
  } dic_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start;
    logic rd_a;
    logic rd_b;
    logic scan;
    logic wr_lo;
    logic wr_hi;
    logic wr_app;
    logic commit;
  } dic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            same_pos;
    logic            scan_done;
    logic            out_free;
  } dic_sts_t;

endpackage

// ===== design/dynamic_inversion_counter_unit.sv =====
// Top level of the dynamic inversion counter: controller plus datapath.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_stall_o   in_data_i  (dic_pkg::in_item_t)
//  out      output     out_valid_o/out_stall_i out_data_o (dic_pkg::out_item_t)
//
// An append scans every stored value and a swap the values between its two positions;
// clear, ignored codes and rejected items skip the scan.
// The time is set by the single memory read port, which scans one stored value a cycle.
// Reset clears the counts and the control state; stored values need no clearing.
// One item is worked on at a time; the next is taken while the last result waits.
// A stalled result holds the block in its final state until the transfer completes.
module dynamic_inversion_counter_unit #(
  parameter int DEPTH      = dic_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dic_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dic_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dic_pkg::out_item_t out_data_o
);

  dic_pkg::dic_cmd_t cmd;
  dic_pkg::dic_sts_t sts;

  dic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dic_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/dic_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module dic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dic_pkg::dic_sts_t sts_i,
  output dic_pkg::dic_cmd_t cmd_o
);

  dic_pkg::dic_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dic_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dic_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dic_pkg::ST_DECODE;
        end
      end
      dic_pkg::ST_DECODE: begin
        if (sts_i.err) begin
          state_d = dic_pkg::ST_FINISH;
        end else if (sts_i.op == dic_pkg::OP_APPEND) begin
          state_d = dic_pkg::ST_SCAN;
        end else if (sts_i.op == dic_pkg::OP_SWAP && !sts_i.same_pos) begin
          state_d = dic_pkg::ST_LOAD_A;
        end else begin
          state_d = dic_pkg::ST_FINISH;
        end
      end
      dic_pkg::ST_LOAD_A: state_d = dic_pkg::ST_LOAD_B;
      dic_pkg::ST_LOAD_B: state_d = dic_pkg::ST_SCAN;
      dic_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = (sts_i.op == dic_pkg::OP_APPEND) ? dic_pkg::ST_WR_APP
                                                     : dic_pkg::ST_WR_LO;
        end
      end
      dic_pkg::ST_WR_LO:  state_d = dic_pkg::ST_WR_HI;
      dic_pkg::ST_WR_HI:  state_d = dic_pkg::ST_FINISH;
      dic_pkg::ST_WR_APP: state_d = dic_pkg::ST_FINISH;
      dic_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = dic_pkg::ST_IDLE;
        end
      end
      default: state_d = dic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dic_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      dic_pkg::ST_DECODE: cmd_o.start  = 1'b1;
      dic_pkg::ST_LOAD_A: cmd_o.rd_a   = 1'b1;
      dic_pkg::ST_LOAD_B: cmd_o.rd_b   = 1'b1;
      dic_pkg::ST_SCAN:   cmd_o.scan   = 1'b1;
      dic_pkg::ST_WR_LO:  cmd_o.wr_lo  = 1'b1;
      dic_pkg::ST_WR_HI:  cmd_o.wr_hi  = 1'b1;
      dic_pkg::ST_WR_APP: cmd_o.wr_app = 1'b1;
      dic_pkg::ST_FINISH: cmd_o.commit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/dic_datapath.sv =====
// Datapath: value memory, scan pointer, accumulator, counters and result register.
`include "assert_macros.svh"
module dic_datapath #(
  parameter int DEPTH      = dic_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dic_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dic_pkg::in_item_t  in_data_i,
  input  dic_pkg::dic_cmd_t  cmd_i,
  output dic_pkg::dic_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dic_pkg::out_item_t out_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > dic_pkg::POS_W) ? CW : dic_pkg::POS_W;

  typedef enum logic [1:0] {
    TAG_A,
    TAG_B,
    TAG_SCAN
  } rd_tag_e;

  logic [VALUE_BITS-1:0] mem_q [DEPTH];

  dic_pkg::in_item_t          item_q;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [dic_pkg::COUNT_W-1:0] inv_q, inv_d;
  logic [dic_pkg::COUNT_W-1:0] acc_q, acc_d;
  logic [AW-1:0]              ptr_q, end_q;
  logic [VALUE_BITS-1:0]      a_q, b_q, rd_data_q;
  logic                       rd_vld_q;
  rd_tag_e                    rd_tag_q, rd_tag_d;
  logic                       out_valid_q;
  dic_pkg::out_item_t         out_q;

  logic [VALUE_BITS-1:0]      item_val;
  logic [dic_pkg::POS_W-1:0]  lo_pos, hi_pos;
  logic [AW-1:0]              lo_addr, hi_addr, rd_addr;
  logic [PW-1:0]              p_ext, q_ext, cnt_ext;
  logic                       err;
  logic                       rd_en;
  logic                       scan_done;
  logic                       out_free;
  logic [1:0]                 inc, dec;

  assign item_val = VALUE_BITS'(item_q.item_value);
  assign lo_pos   = (item_q.first_position < item_q.second_position) ?
                    item_q.first_position : item_q.second_position;
  assign hi_pos   = (item_q.first_position < item_q.second_position) ?
                    item_q.second_position : item_q.first_position;
  assign lo_addr  = AW'(lo_pos);
  assign hi_addr  = AW'(hi_pos);
  assign p_ext    = PW'(item_q.first_position);
  assign q_ext    = PW'(item_q.second_position);
  assign cnt_ext  = PW'(cnt_q);

  always_comb begin
    case (item_q.operation)
      dic_pkg::OP_APPEND: err = (cnt_q == CW'(DEPTH));
      dic_pkg::OP_SWAP:   err = (p_ext >= cnt_ext) || (q_ext >= cnt_ext);
      default:            err = 1'b0;
    endcase
  end

  assign scan_done = (ptr_q == end_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.op        = item_q.operation;
  assign sts_o.err       = err;
  assign sts_o.same_pos  = (item_q.first_position == item_q.second_position);
  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = out_free;

  // One memory read per cycle: for a swap the two swapped values first, then the scan.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = ptr_q;
    rd_tag_d = TAG_SCAN;
    if (cmd_i.rd_a) begin
      rd_en    = 1'b1;
      rd_addr  = lo_addr;
      rd_tag_d = TAG_A;
    end else if (cmd_i.rd_b) begin
      rd_en    = 1'b1;
      rd_addr  = hi_addr;
      rd_tag_d = TAG_B;
    end else if (cmd_i.scan && !scan_done) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_lo) begin
      mem_q[lo_addr] <= b_q;
    end else if (cmd_i.wr_hi) begin
      mem_q[hi_addr] <= a_q;
    end else if (cmd_i.wr_app) begin
      mem_q[AW'(cnt_q)] <= item_val;
    end
  end

  // Per-element change of the count; a swap weighs the scanned value against both moved ones.
  always_comb begin
    inc = 2'd0;
    dec = 2'd0;
    if (item_q.operation == dic_pkg::OP_APPEND) begin
      inc = {1'b0, rd_data_q > item_val};
    end else begin
      inc = 2'(rd_data_q > a_q) + 2'(rd_data_q < b_q);
      dec = 2'(rd_data_q < a_q) + 2'(rd_data_q > b_q);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = inv_q;
    end else if (rd_vld_q && rd_tag_q == TAG_SCAN) begin
      acc_d = acc_q + dic_pkg::COUNT_W'(inc) - dic_pkg::COUNT_W'(dec);
    end else if (cmd_i.wr_lo) begin
      if (a_q < b_q) begin
        acc_d = acc_q + dic_pkg::COUNT_W'(1);
      end else if (a_q > b_q) begin
        acc_d = acc_q - dic_pkg::COUNT_W'(1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    inv_d = inv_q;
    case (item_q.operation)
      dic_pkg::OP_APPEND: begin
        if (!err) begin
          cnt_d = cnt_q + CW'(1);
          inv_d = acc_q;
        end
      end
      dic_pkg::OP_SWAP: begin
        if (!err) begin
          inv_d = acc_q;
        end
      end
      dic_pkg::OP_CLEAR: begin
        cnt_d = '0;
        inv_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
        inv_d = inv_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    acc_q <= acc_d;
    if (cmd_i.start) begin
      if (item_q.operation == dic_pkg::OP_APPEND) begin
        ptr_q <= '0;
        end_q <= AW'(cnt_q);
      end else begin
        ptr_q <= lo_addr + AW'(1);
        end_q <= hi_addr;
      end
    end else if (rd_en && cmd_i.scan) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_tag_q <= rd_tag_d;
    end
    if (rd_vld_q && rd_tag_q == TAG_A) begin
      a_q <= rd_data_q;
    end
    if (rd_vld_q && rd_tag_q == TAG_B) begin
      b_q <= rd_data_q;
    end
    if (cmd_i.commit) begin
      out_q.inversion_count <= inv_d;
      out_q.element_count   <= dic_pkg::ELEMS_W'(cnt_d);
      out_q.error           <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      inv_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.commit) begin
        cnt_q       <= cnt_d;
        inv_q       <= inv_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLY(a_rd_follows_issue, clk_i, rst_ni, rd_vld_q, $past(rd_en), "read data without a read")
  `ASSERT_NEVER(a_wr_during_read, clk_i, rst_ni, (cmd_i.wr_lo || cmd_i.wr_hi || cmd_i.wr_app) && rd_vld_q, "memory write while read data is pending")
  `ASSERT_IMPLY(a_result_from_commit, clk_i, rst_ni, $rose(out_valid_q), $past(cmd_i.commit), "result without a commit")
  `ASSERT_IMPLY(a_count_in_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "element count above depth")

endmodule

// ===== dv/tb_dynamic_inversion_counter_unit.sv =====
// Self-checking testbench for dynamic_inversion_counter_unit with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_dynamic_inversion_counter_unit;

  localparam logic [dic_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS    = 130;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;

  class inversion_scoreboard;
    bit [dic_pkg::VALUE_BITS_DEF-1:0] values [dic_pkg::DEPTH_DEF];
    int unsigned                      held;
    bit [19:0]                        inversions;
    dic_pkg::out_item_t               awaited [$];
    int unsigned                      mismatches;

    function new();
      held       = 0;
      inversions = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Updates the shadow sequence for one accepted transfer and queues its result.
    function void note_input(input dic_pkg::in_item_t it);
      dic_pkg::out_item_t               res;
      bit                               err;
      int unsigned                      lo;
      int unsigned                      hi;
      bit [dic_pkg::VALUE_BITS_DEF-1:0] a;
      bit [dic_pkg::VALUE_BITS_DEF-1:0] b;
      bit [dic_pkg::VALUE_BITS_DEF-1:0] v;
      err = 1'b0;
      case (it.operation)
        dic_pkg::OP_APPEND: begin
          if (held >= dic_pkg::DEPTH_DEF) begin
            err = 1'b1;
          end else begin
            for (int k = 0; k < held; k++) begin
              if (values[k] > it.item_value) inversions++;
            end
            values[held] = it.item_value;
            held++;
          end
        end
        dic_pkg::OP_SWAP: begin
          if (it.first_position >= held || it.second_position >= held) begin
            err = 1'b1;
          end else begin
            lo = (it.first_position < it.second_position) ? it.first_position
                                                           : it.second_position;
            hi = (it.first_position < it.second_position) ? it.second_position
                                                           : it.first_position;
            a = values[lo];
            b = values[hi];
            // Only values strictly between the two positions change their pairing.
            for (int k = lo + 1; k < hi; k++) begin
              v = values[k];
              if (v < a) inversions--;
              if (v > a) inversions++;
              if (v < b) inversions++;
              if (v > b) inversions--;
            end
            if (a < b) inversions++;
            else if (a > b) inversions--;
            values[lo] = b;
            values[hi] = a;
          end
        end
        dic_pkg::OP_CLEAR: begin
          held       = 0;
          inversions = '0;
        end
        default: ;
      endcase
      res.inversion_count = inversions[dic_pkg::COUNT_W-1:0];
      res.element_count   = held[dic_pkg::ELEMS_W-1:0];
      res.error           = err;
      awaited.push_back(res);
    endfunction

    task check_result(input dic_pkg::out_item_t got);
      dic_pkg::out_item_t exp;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited: %p", got));
      end else begin
        exp = awaited.pop_front();
        if (got.inversion_count !== exp.inversion_count)
          report_mismatch($sformatf("inversion_count %0d, predicted %0d",
                                    got.inversion_count, exp.inversion_count));
        if (got.element_count !== exp.element_count)
          report_mismatch($sformatf("element_count %0d, predicted %0d",
                                    got.element_count, exp.element_count));
        if (got.error !== exp.error)
          report_mismatch($sformatf("error %0b, predicted %0b", got.error, exp.error));
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  dic_pkg::in_item_t  in_data_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  dic_pkg::out_item_t out_data_o;

  inversion_scoreboard sb = new();

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          hold_left      = 0;
  int          idle_cycles    = 0;
  int unsigned shadow_held    = 0;

  dynamic_inversion_counter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // A result accepted at the same edge as an input always belongs to an earlier item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dynamic_inversion_counter_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input dic_pkg::in_item_t it);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic issue(input logic [dic_pkg::OP_W-1:0] op,
                       input logic [dic_pkg::IVAL_W-1:0] val,
                       input logic [dic_pkg::POS_W-1:0] p,
                       input logic [dic_pkg::POS_W-1:0] q);
    dic_pkg::in_item_t it;
    it.operation       = op;
    it.item_value      = val;
    it.first_position  = p;
    it.second_position = q;
    if (op == dic_pkg::OP_APPEND && shadow_held < dic_pkg::DEPTH_DEF) shadow_held++;
    if (op == dic_pkg::OP_CLEAR) shadow_held = 0;
    send_item(it);
  endtask

  function automatic logic [dic_pkg::POS_W-1:0] any_pos();
    return dic_pkg::POS_W'($urandom());
  endfunction

  function automatic logic [dic_pkg::IVAL_W-1:0] pick_value();
    // Small values give many equal pairs; full-range values cover every bit.
    return ($urandom_range(2) == 0) ? dic_pkg::IVAL_W'($urandom_range(7))
                                    : dic_pkg::IVAL_W'($urandom());
  endfunction

  task automatic run_random_phase();
    int          issued;
    int          roll;
    int unsigned seq_limit;
    issued    = 0;
    seq_limit = $urandom_range(4, 48);
    while (issued < PHASE_ITEMS) begin
      roll = $urandom_range(99);
      if (shadow_held >= seq_limit || (roll >= 88 && roll < 92)) begin
        issue(dic_pkg::OP_CLEAR, $urandom(), any_pos(), any_pos());
        seq_limit = $urandom_range(4, 48);
        issued++;
      end else if (roll < 88) begin
        if (shadow_held == 0 || roll < 45)
          issue(dic_pkg::OP_APPEND, pick_value(), any_pos(), any_pos());
        else
          issue(dic_pkg::OP_SWAP, $urandom(),
                dic_pkg::POS_W'($urandom_range(shadow_held - 1)),
                dic_pkg::POS_W'($urandom_range(shadow_held - 1)));
        issued++;
      end else if (roll < 96) begin
        issue(OP_UNUSED, $urandom(), any_pos(), any_pos());
      end else begin
        // Unconstrained positions are mostly out of range.
        issue(dic_pkg::OP_SWAP, $urandom(), any_pos(), any_pos());
        issued++;
      end
    end
  endtask

  int src_pcts  [4] = '{0, 72, 0, 27};
  int sink_pcts [4] = '{0, 0, 72, 27};

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty sequence, extremes of the value, equal values and both swap orders.
    issue(dic_pkg::OP_CLEAR, '0, '0, '0);
    issue(OP_UNUSED, '1, '1, '1);
    issue(dic_pkg::OP_SWAP, '0, '0, '0);
    issue(dic_pkg::OP_APPEND, 32'hFFFF_FFFF, '0, '0);
    issue(dic_pkg::OP_APPEND, 32'h0000_0000, '1, '1);
    issue(dic_pkg::OP_APPEND, 32'h0000_0000, '0, '0);
    issue(dic_pkg::OP_APPEND, 32'h8000_0000, '0, '0);
    issue(dic_pkg::OP_APPEND, 32'hFFFF_FFFF, '0, '0);
    issue(dic_pkg::OP_SWAP, '0, 10'd4, 10'd0);
    issue(dic_pkg::OP_SWAP, '1, 10'd1, 10'd3);
    issue(dic_pkg::OP_SWAP, '0, 10'd2, 10'd2);
    issue(dic_pkg::OP_SWAP, '0, 10'd5, 10'd0);
    issue(dic_pkg::OP_SWAP, '0, 10'd0, 10'd1023);
    issue(OP_UNUSED, 32'h5A5A_A5A5, 10'h155, 10'h2AA);
    issue(dic_pkg::OP_APPEND, 32'd5, '0, '0);
    issue(dic_pkg::OP_CLEAR, '1, '1, '1);

    // A longer sequence, a swap across all of it, and positions far out of range.
    repeat (24) issue(dic_pkg::OP_APPEND, pick_value(), any_pos(), any_pos());
    issue(dic_pkg::OP_APPEND, $urandom(), '0, '0);
    issue(dic_pkg::OP_SWAP, '0, 10'd1023, 10'd0);
    issue(dic_pkg::OP_SWAP, '1, 10'd0, 10'd24);
    issue(dic_pkg::OP_SWAP, '0, 10'd512, 10'd511);
    issue(OP_UNUSED, $urandom(), any_pos(), any_pos());
    issue(dic_pkg::OP_CLEAR, '0, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pcts[ph];
      sink_stall_pct = sink_pcts[ph];
      if (ph == 0) begin
        // Long receiver hold-off while items keep coming, so the input backs up.
        @(posedge clk_i);
        hold_left = HOLD_CYCLES;
        @(negedge clk_i);
      end
      run_random_phase();
    end

    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("dynamic_inversion_counter_unit verification clean");
    end else begin
      $display("dynamic_inversion_counter_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dic_pkg.sv
design/dic_ctrl.sv
design/dic_datapath.sv
design/dynamic_inversion_counter_unit.sv
dv/tb_dynamic_inversion_counter_unit.sv
